// ----- rtl/spd_pkg.sv -----
// -----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the slope peak detector.
// -----------------------------------------------------------------------------
package spd_pkg;

  localparam int MAX_LENGTH      = 1024;
  localparam int MAX_HALF_WINDOW = 7;

  localparam int SAMPLE_W = 24;
  localparam int HW_W     = 3;
  localparam int POS_W    = $clog2(MAX_LENGTH);
  localparam int COUNT_W  = POS_W + 1;
  localparam int LEN_W    = 12;
  localparam int TAPS     = 2 * MAX_HALF_WINDOW;
  localparam int TAP_W    = $clog2(TAPS);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(2 * MAX_LENGTH - 1);

  // register indexes on the config port
  localparam logic [0:0] REG_HALF_WINDOW = 1'b0;
  localparam logic [HW_W-1:0] HALF_WINDOW_RST = HW_W'(1);

  typedef enum logic [1:0] {
    SLOPE_FLAT = 2'd0,
    SLOPE_FALL = 2'd1,
    SLOPE_RISE = 2'd2
  } slope_t;

  // slope judgement for the incoming word plus the two crest samples
  typedef struct packed {
    slope_t              slope;
    logic [SAMPLE_W-1:0] up_end_val;
    logic [SAMPLE_W-1:0] down_start_val;
  } win_t;

endpackage

// ----- rtl/spd_window.sv -----
// -----------------------------------------------------------------------------
// spd_window
// Sample delay line and slope sign of sample[i+h] against sample[i-h].
// -----------------------------------------------------------------------------
module spd_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift_en,
  input  logic                             clear,
  input  logic [spd_pkg::SAMPLE_W-1:0]     sample,
  input  logic [spd_pkg::HW_W-1:0]         half_window,
  output spd_pkg::win_t                    win
);

  logic [spd_pkg::SAMPLE_W-1:0] taps_r [spd_pkg::TAPS];
  logic [spd_pkg::SAMPLE_W-1:0] taps_nxt [spd_pkg::TAPS];
  logic [spd_pkg::SAMPLE_W-1:0] far_val;
  logic [spd_pkg::TAP_W-1:0]    far_idx;
  logic [spd_pkg::TAP_W-1:0]    mid_idx;
  logic [spd_pkg::TAP_W-1:0]    mid_m1_idx;

  // taps_r[k] holds the sample k+1 words back from the incoming one
  assign far_idx    = spd_pkg::TAP_W'({half_window, 1'b0} - 4'd1);
  assign mid_idx    = spd_pkg::TAP_W'(half_window);
  assign mid_m1_idx = spd_pkg::TAP_W'(half_window - 3'd1);

  always_comb begin
    far_val = (half_window == '0) ? sample : taps_r[far_idx];
    if (sample > far_val) begin
      win.slope = spd_pkg::SLOPE_RISE;
    end else if (sample < far_val) begin
      win.slope = spd_pkg::SLOPE_FALL;
    end else begin
      win.slope = spd_pkg::SLOPE_FLAT;
    end
    win.up_end_val     = taps_r[mid_idx];
    win.down_start_val = (half_window == '0) ? sample : taps_r[mid_m1_idx];
  end

  always_comb begin
    taps_nxt[0] = sample;
    for (int k = 1; k < spd_pkg::TAPS; k++) begin
      taps_nxt[k] = taps_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (shift_en && clear)) begin
      for (int k = 0; k < spd_pkg::TAPS; k++) begin
        taps_r[k] <= '0;
      end
    end else if (shift_en) begin
      for (int k = 0; k < spd_pkg::TAPS; k++) begin
        taps_r[k] <= taps_nxt[k];
      end
    end
  end

endmodule

// ----- rtl/slope_peak_detector_core.sv -----
// -----------------------------------------------------------------------------
// slope_peak_detector_core
// Peak detector on the sign of a windowed slope over a sample stream.
// -----------------------------------------------------------------------------
// Usage:
//   in_*  : one sample word per handshake (tdata = 16.8 sample, tlast ends the
//           sequence and clears all sequence state after that word).
//   out_* : one peak word when a falling run ends; most input words give none.
//   cfg_* : APB register 0 = half_window (3 bits, reset 1); write while idle.
// Output: a peak word is registered and presented on out_* in the cycle after
//   the input word that ends the falling run.
// Throughput: one input word per cycle unless stalled; the whole judgement is
//   one compare and a few register updates done as the word is accepted.
// Stall: the result register holds until out_tready; in_tready stays high
//   while that register is empty or being drained in the same cycle.
// Reset: synchronous, active low; clears the delay line, the counters, the
//   crest records and the result valid flag, and sets half_window to 1.
// -----------------------------------------------------------------------------
module slope_peak_detector_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [23:0] sample
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [spd_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tlast,
  // out_tdata: [9:0] peak_position, [21:10] left_length, [33:22] right_length,
  //            [57:34] peak_value, [63:58] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [spd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PW = spd_pkg::POS_W;
  localparam int LW = spd_pkg::LEN_W;
  localparam int SW = spd_pkg::SAMPLE_W;
  localparam int CW = spd_pkg::COUNT_W;

  logic [spd_pkg::HW_W-1:0] half_window_r;
  logic [spd_pkg::HW_W-1:0] h;
  logic                     cfg_wr;

  logic [CW-1:0]    count_r;
  spd_pkg::slope_t  prev_slope_r;
  logic [PW-1:0]    up_start_r;
  logic [PW-1:0]    up_end_r;
  logic [PW-1:0]    down_start_r;
  logic [SW-1:0]    up_end_val_r;
  logic [SW-1:0]    down_start_val_r;

  logic             out_valid_r;
  logic [PW-1:0]    peak_pos_r;
  logic [LW-1:0]    left_len_r;
  logic [LW-1:0]    right_len_r;
  logic [SW-1:0]    peak_val_r;

  logic             acc;
  logic             judge;
  logic             emit;
  logic [CW-1:0]    pos_full;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    prev_pos;
  logic [PW-1:0]    peak_pos_nxt;
  logic [SW-1:0]    peak_val_nxt;
  logic [LW-1:0]    left_len_nxt;
  logic [LW-1:0]    right_len_nxt;
  spd_pkg::win_t    win;

  // ---- config port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == spd_pkg::REG_HALF_WINDOW);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == spd_pkg::REG_HALF_WINDOW) begin
      cfg_prdata = 32'(half_window_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_window_r <= spd_pkg::HALF_WINDOW_RST;
    end else if (cfg_wr) begin
      half_window_r <= cfg_pwdata[spd_pkg::HW_W-1:0];
    end
  end

  assign h = (half_window_r > spd_pkg::HW_W'(spd_pkg::MAX_HALF_WINDOW)) ?
             spd_pkg::HW_W'(spd_pkg::MAX_HALF_WINDOW) : half_window_r;

  // ---- slope judgement ----
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  spd_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (acc),
    .clear       (in_tlast),
    .sample      (in_tdata[SW-1:0]),
    .half_window (h),
    .win         (win)
  );

  assign judge    = count_r >= CW'({h, 1'b0});
  assign pos_full = count_r - CW'(h);
  assign pos      = pos_full[PW-1:0];
  assign prev_pos = pos - PW'(1);
  assign emit     = judge && (prev_slope_r == spd_pkg::SLOPE_FALL) &&
                    (win.slope != spd_pkg::SLOPE_FALL);

  always_comb begin
    // tie goes to the uphill end
    if (up_end_val_r < down_start_val_r) begin
      peak_pos_nxt = down_start_r;
      peak_val_nxt = down_start_val_r;
    end else begin
      peak_pos_nxt = up_end_r;
      peak_val_nxt = up_end_val_r;
    end
    left_len_nxt  = LW'(up_end_r) - LW'(up_start_r) + LW'(1);
    right_len_nxt = LW'(prev_pos) - LW'(down_start_r) + LW'(1);
  end

  // ---- sequence state ----
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_tlast)) begin
      count_r          <= '0;
      prev_slope_r     <= spd_pkg::SLOPE_FLAT;
      up_start_r       <= '0;
      up_end_r         <= '0;
      down_start_r     <= '0;
      up_end_val_r     <= '0;
      down_start_val_r <= '0;
    end else if (acc) begin
      if (count_r < spd_pkg::COUNT_MAX) begin
        count_r <= count_r + CW'(1);
      end
      if (judge) begin
        prev_slope_r <= win.slope;
        if (prev_slope_r == spd_pkg::SLOPE_FLAT && win.slope == spd_pkg::SLOPE_RISE) begin
          up_start_r <= pos;
        end else if (prev_slope_r == spd_pkg::SLOPE_RISE &&
                     win.slope == spd_pkg::SLOPE_FALL) begin
          up_end_r         <= prev_pos;
          down_start_r     <= pos;
          up_end_val_r     <= win.up_end_val;
          down_start_val_r <= win.down_start_val;
        end
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      peak_pos_r  <= peak_pos_nxt;
      left_len_r  <= left_len_nxt;
      right_len_r <= right_len_nxt;
      peak_val_r  <= peak_val_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, peak_val_r, right_len_r, left_len_r, peak_pos_r};

endmodule

// ----- test/tb_slope_peak_detector_core.sv -----
// -----------------------------------------------------------------------------
// tb_slope_peak_detector_core
// Self-checking bench for the slope peak detector core. Sample words are queued
// by the sequencer, sent by a stream driver with random gaps, and run through
// a cycle-free peak predictor as they are accepted. A monitor with random
// back-pressure compares every peak word field by field against the oldest
// predicted peak. The half window is rewritten over APB between phases.
// -----------------------------------------------------------------------------
module tb_slope_peak_detector_core;

  localparam logic [2:0] HW_ADDR = 3'(4 * spd_pkg::REG_HALF_WINDOW);
  localparam int DLINE_D = 2 * spd_pkg::MAX_HALF_WINDOW + 1;
  localparam logic [spd_pkg::SAMPLE_W-1:0] SAMPLE_MAX = {spd_pkg::SAMPLE_W{1'b1}};
  localparam int PHASE_WORDS = 65;
  localparam int LONG_RUN_WORDS = 1050;

  typedef struct {
    logic [spd_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
  } sample_word_t;

  typedef struct {
    logic [spd_pkg::POS_W-1:0]    position;
    logic [spd_pkg::LEN_W-1:0]    left_len;
    logic [spd_pkg::LEN_W-1:0]    right_len;
    logic [spd_pkg::SAMPLE_W-1:0] value;
  } peak_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spd_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [spd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [2:0]                     cfg_paddr = '0;
  logic [31:0]                    cfg_pwdata = '0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  slope_peak_detector_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sample_word_t sample_q[$];
  peak_t        peak_q[$];
  int           words_left = 0;
  int           phase_words = 0;
  int           err_cnt = 0;
  bit           idle_on = 1'b1;

  // predictor state
  logic [spd_pkg::HW_W-1:0]     half_win = spd_pkg::HALF_WINDOW_RST;
  logic [spd_pkg::SAMPLE_W-1:0] dline[DLINE_D];
  logic [spd_pkg::COUNT_W-1:0]  sample_cnt;
  spd_pkg::slope_t              prev_slope;
  logic [spd_pkg::POS_W-1:0]    up_start, up_end, dn_start;
  logic [spd_pkg::SAMPLE_W-1:0] up_end_val, dn_start_val;

  function automatic void clear_run();
    for (int k = 0; k < DLINE_D; k++) dline[k] = '0;
    sample_cnt   = '0;
    prev_slope   = spd_pkg::SLOPE_FLAT;
    up_start     = '0;
    up_end       = '0;
    dn_start     = '0;
    up_end_val   = '0;
    dn_start_val = '0;
  endfunction

  function automatic void predict_peak(logic [spd_pkg::SAMPLE_W-1:0] s, logic last);
    logic [spd_pkg::COUNT_W-1:0]  j;
    logic [spd_pkg::POS_W-1:0]    pos, prev_pos;
    logic [spd_pkg::SAMPLE_W-1:0] a, b;
    spd_pkg::slope_t              cur;
    peak_t                        pk;
    int                           h;
    h = int'(half_win);
    j = sample_cnt;
    for (int k = DLINE_D - 1; k > 0; k--) dline[k] = dline[k-1];
    dline[0] = s;
    if (int'(j) >= 2 * h) begin
      pos      = spd_pkg::POS_W'(int'(j) - h);
      prev_pos = pos - 1'b1;
      a = dline[0];
      b = dline[2*h];
      cur = (a > b) ? spd_pkg::SLOPE_RISE :
            ((a < b) ? spd_pkg::SLOPE_FALL : spd_pkg::SLOPE_FLAT);
      if (prev_slope == spd_pkg::SLOPE_FLAT && cur == spd_pkg::SLOPE_RISE) begin
        up_start = pos;
      end else if (prev_slope == spd_pkg::SLOPE_RISE && cur == spd_pkg::SLOPE_FALL) begin
        up_end       = prev_pos;
        dn_start     = pos;
        up_end_val   = dline[h+1];
        dn_start_val = dline[h];
      end
      if (prev_slope == spd_pkg::SLOPE_FALL && cur != spd_pkg::SLOPE_FALL) begin
        // tie goes to the uphill end
        if (up_end_val < dn_start_val) begin
          pk.position = dn_start;
          pk.value    = dn_start_val;
        end else begin
          pk.position = up_end;
          pk.value    = up_end_val;
        end
        pk.left_len  = spd_pkg::LEN_W'({2'b00, up_end}) -
                       spd_pkg::LEN_W'({2'b00, up_start}) + 1'b1;
        pk.right_len = spd_pkg::LEN_W'({2'b00, prev_pos}) -
                       spd_pkg::LEN_W'({2'b00, dn_start}) + 1'b1;
        peak_q = {peak_q, pk};
      end
      prev_slope = cur;
    end
    if (j < spd_pkg::COUNT_MAX) sample_cnt = j + 1'b1;
    if (last) clear_run();
  endfunction

  initial clear_run();

  // stream driver
  int in_gap = 0;
  always @(posedge clk) begin
    sample_word_t w;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_peak(in_tdata[spd_pkg::SAMPLE_W-1:0], in_tlast);
        words_left--;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          w = sample_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= spd_pkg::IN_DATA_W'(w.sample);
          in_tlast  <= w.last;
          if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int out_stall = 0;
  always @(posedge clk) begin
    peak_t pk;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (peak_q.size() == 0) begin
          $error("unexpected peak word %h", out_tdata);
          err_cnt++;
        end else begin
          pk = peak_q.pop_front();
          if (out_tdata[9:0] !== pk.position) begin
            $error("peak_position exp %0d got %0d", pk.position, out_tdata[9:0]);
            err_cnt++;
          end
          if (out_tdata[21:10] !== pk.left_len) begin
            $error("left_length exp %h got %h", pk.left_len, out_tdata[21:10]);
            err_cnt++;
          end
          if (out_tdata[33:22] !== pk.right_len) begin
            $error("right_length exp %h got %h", pk.right_len, out_tdata[33:22]);
            err_cnt++;
          end
          if (out_tdata[57:34] !== pk.value) begin
            $error("peak_value exp %h got %h", pk.value, out_tdata[57:34]);
            err_cnt++;
          end
          if (out_tdata[63:58] !== 6'd0) begin
            $error("pad exp 0 got %h", out_tdata[63:58]);
            err_cnt++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 13);
      end
    end
  end

  task automatic push_word(logic [spd_pkg::SAMPLE_W-1:0] s, logic last);
    sample_word_t w;
    w.sample = s;
    w.last   = last;
    sample_q = {sample_q, w};
    words_left++;
    phase_words++;
  endtask

  // random walk built from flat, rising and falling segments
  task automatic push_shape(int n, bit close_run);
    longint v, stp;
    int     kind, run, k;
    v = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, SAMPLE_MAX);
    k = 0;
    while (k < n) begin
      kind = $urandom_range(0, 2);
      run  = $urandom_range(1, 10);
      stp  = longint'($urandom_range(1, 255)) << $urandom_range(0, 15);
      for (int r = 0; r < run && k < n; r++) begin
        if (kind == 1) v += stp;
        else if (kind == 2) v -= stp;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        push_word(spd_pkg::SAMPLE_W'(v), close_run && k == n - 1);
        k++;
      end
    end
  endtask

  task automatic push_noise(int n, bit close_run);
    logic [spd_pkg::SAMPLE_W-1:0] s;
    int                           sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      s = sel == 0 ? '0 : (sel == 1 ? SAMPLE_MAX : spd_pkg::SAMPLE_W'($urandom));
      push_word(s, (close_run && k == n - 1) || $urandom_range(0, 49) == 0);
    end
  endtask

  // hold off until every word is in and every peak is out, plus pipeline slack
  task automatic wait_drained();
    do @(posedge clk); while (words_left != 0 || peak_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_window(logic [spd_pkg::HW_W-1:0] hw);
    logic [31:0] wdata;
    wdata = $urandom;
    wdata[spd_pkg::HW_W-1:0] = hw;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= HW_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    half_win = hw;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {{(32-spd_pkg::HW_W){1'b0}}, hw}) begin
      $error("half_window readback exp %0d got %h", hw, cfg_prdata);
      err_cnt++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  logic [spd_pkg::HW_W-1:0] hw_plan[10] =
    '{3'd7, 3'd0, 3'd3, 3'd2, 3'd5, 3'd4, 3'd6, 3'd1, 3'd0, 3'd7};
  logic [spd_pkg::SAMPLE_W-1:0] dir_samples[22] = '{
    24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000,
    24'h000000, 24'h000800, 24'h000800, 24'h000800, 24'h000500, 24'h000100,
    24'h000000, 24'h000300, 24'h000700, 24'h000700, 24'h000200, 24'h000200,
    24'h000900, 24'h000001, 24'hFFFFFE, 24'h000000};
  logic dir_last[22] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

  initial begin
    int n;
    bit open_end;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, flat to falling, falling to rising on stale records,
    // last in mid-flight, then a short run, all at the reset window
    for (int k = 0; k < 22; k++) push_word(dir_samples[k], dir_last[k]);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      if (p == 9) idle_on = 1'b0;
      write_half_window(hw_plan[p]);
      // run long enough to wrap the positions
      if (p == 3) push_shape(LONG_RUN_WORDS, 1'b1);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        n = $urandom_range(0, 7) == 0 ? $urandom_range(41, 120) : $urandom_range(4, 40);
        // leave the last run open now and then so the next window lands mid-run
        open_end = phase_words + n >= PHASE_WORDS && $urandom_range(0, 1) == 1;
        if ($urandom_range(0, 4) == 0) push_noise(n, !open_end);
        else push_shape(n, !open_end);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spd_pkg.sv
rtl/spd_window.sv
rtl/slope_peak_detector_core.sv
test/tb_slope_peak_detector_core.sv
